>>> src/smpq_pkg.sv
// Shared types and constants for the stable minimum priority queue.
`timescale 1ns / 1ps

package smpq_pkg;

	// Default store depth
	localparam int QueueDepthDef = 64;

	// Field widths
	localparam int AmountW = 32;
	localparam int IdW     = 16;
	localparam int LimitW  = 16;
	localparam int CapW    = 7;
	localparam int CfgIdxW = 2;

	// Register reset values
	localparam logic [LimitW-1:0]         TotalLimitRst = 16'hFFFF;
	localparam logic [CapW-1:0]           CapacityRst   = 7'd64;
	localparam logic signed [AmountW-1:0] ThresholdRst  = 32'sd2000;

	// Configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		CFG_TOTAL_LIMIT = 2'd0,
		CFG_CAPACITY    = 2'd1,
		CFG_THRESHOLD   = 2'd2
	} cfg_idx_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_INS_WR,
		ST_POP_RD,
		ST_FINISH
	} state_t;

	// Source of the result id
	typedef enum logic [1:0] {
		RES_KEEP,
		RES_ZERO,
		RES_NEW,
		RES_POP
	} res_sel_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic     load_item;
		logic     k_load;
		logic     k_dec;
		logic     rd_en;
		logic     rd_head;
		logic     wr_shift;
		logic     wr_new;
		logic     ins_commit;
		logic     pop_commit;
		res_sel_t res_sel;
		logic     push;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic is_pop;
		logic limit_hit;
		logic ins_ok;
		logic not_empty;
		logic k_one;
		logic rd_greater;
		logic out_free;
	} status_t;

endpackage

>>> src/smpq_ctrl.sv
// Controller state machine for the priority queue.
`timescale 1ns / 1ps

module smpq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  smpq_pkg::status_t sts,
	output smpq_pkg::cmd_t   cmd
);

	smpq_pkg::state_t state_q, state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smpq_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			smpq_pkg::ST_IDLE: begin
				if (in_valid) state_nxt = smpq_pkg::ST_DECIDE;
			end
			smpq_pkg::ST_DECIDE: begin
				if (sts.limit_hit) begin
					state_nxt = smpq_pkg::ST_FINISH;
				end else if (sts.is_pop) begin
					state_nxt = sts.not_empty ? smpq_pkg::ST_POP_RD : smpq_pkg::ST_FINISH;
				end else if (!sts.ins_ok) begin
					state_nxt = smpq_pkg::ST_FINISH;
				end else begin
					state_nxt = sts.not_empty ? smpq_pkg::ST_INS_RD : smpq_pkg::ST_INS_WR;
				end
			end
			smpq_pkg::ST_INS_RD: begin
				state_nxt = smpq_pkg::ST_INS_CMP;
			end
			smpq_pkg::ST_INS_CMP: begin
				if (sts.rd_greater && !sts.k_one) state_nxt = smpq_pkg::ST_INS_RD;
				else state_nxt = smpq_pkg::ST_INS_WR;
			end
			smpq_pkg::ST_INS_WR: begin
				state_nxt = smpq_pkg::ST_FINISH;
			end
			smpq_pkg::ST_POP_RD: begin
				state_nxt = smpq_pkg::ST_FINISH;
			end
			smpq_pkg::ST_FINISH: begin
				if (sts.out_free) state_nxt = smpq_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = smpq_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		cmd.res_sel = smpq_pkg::RES_KEEP;
		in_ready = 1'b0;
		case (state_q)
			smpq_pkg::ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.load_item = in_valid;
			end
			smpq_pkg::ST_DECIDE: begin
				if (sts.limit_hit) begin
					cmd.res_sel = smpq_pkg::RES_ZERO;
				end else if (sts.is_pop) begin
					if (sts.not_empty) begin
						cmd.rd_en   = 1'b1;
						cmd.rd_head = 1'b1;
					end else begin
						cmd.res_sel = smpq_pkg::RES_ZERO;
					end
				end else if (!sts.ins_ok) begin
					cmd.res_sel = smpq_pkg::RES_ZERO;
				end else begin
					cmd.k_load = 1'b1;
				end
			end
			smpq_pkg::ST_INS_RD: begin
				cmd.rd_en = 1'b1;
			end
			smpq_pkg::ST_INS_CMP: begin
				if (sts.rd_greater) begin
					cmd.wr_shift = 1'b1;
					cmd.k_dec    = 1'b1;
				end
			end
			smpq_pkg::ST_INS_WR: begin
				cmd.wr_new     = 1'b1;
				cmd.ins_commit = 1'b1;
				cmd.res_sel    = smpq_pkg::RES_NEW;
			end
			smpq_pkg::ST_POP_RD: begin
				cmd.pop_commit = 1'b1;
				cmd.res_sel    = smpq_pkg::RES_POP;
			end
			smpq_pkg::ST_FINISH: begin
				cmd.push = sts.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

>>> src/smpq_datapath.sv
// Datapath: circular sorted store, counters, config registers, result register.
`timescale 1ns / 1ps

module smpq_datapath #(
	parameter int QUEUE_DEPTH = smpq_pkg::QueueDepthDef
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input item
	input  logic                                 in_action,
	input  logic signed [smpq_pkg::AmountW-1:0]  in_amount,
	// configuration
	input  logic                                 cfg_we,
	input  logic [smpq_pkg::CfgIdxW-1:0]         cfg_idx,
	input  logic [smpq_pkg::AmountW-1:0]         cfg_wdata,
	// result
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [smpq_pkg::IdW-1:0]             out_id,
	output logic signed [smpq_pkg::AmountW-1:0]  out_amount,
	// control
	input  smpq_pkg::cmd_t                       cmd,
	output smpq_pkg::status_t                    sts
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int MW = smpq_pkg::AmountW + smpq_pkg::IdW;
	localparam logic [AW:0] DepthW = (AW + 1)'(QUEUE_DEPTH);

	// Config registers
	logic [smpq_pkg::LimitW-1:0]          total_limit_q;
	logic [smpq_pkg::CapW-1:0]            capacity_q;
	logic signed [smpq_pkg::AmountW-1:0]  threshold_q;

	// Queue state
	logic [MW-1:0]               mem [QUEUE_DEPTH];
	logic [MW-1:0]               rdata_q;
	logic [AW-1:0]               head_q;
	logic [CW-1:0]               count_q;
	logic [AW-1:0]               k_q;
	logic [smpq_pkg::IdW-1:0]    next_id_q;
	logic [smpq_pkg::LimitW-1:0] admitted_q;

	// Current item
	logic                                action_q;
	logic signed [smpq_pkg::AmountW-1:0] amount_q;

	// Result
	logic [smpq_pkg::IdW-1:0]             res_id_q;
	logic                                 out_valid_q;
	logic [smpq_pkg::IdW-1:0]             out_id_q;
	logic signed [smpq_pkg::AmountW-1:0]  out_amount_q;

	logic [smpq_pkg::IdW-1:0]             new_id;
	logic [AW-1:0]                        k_m1;
	logic [AW-1:0]                        wr_addr, rd_addr, head_nxt;
	logic [MW-1:0]                        wr_data;
	logic signed [smpq_pkg::AmountW-1:0]  rd_amount;

	// Logical slot to physical address, wrapping at the depth
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [AW-1:0] ofs);
		logic [AW:0] sum;
		sum = {1'b0, base} + {1'b0, ofs};
		if (sum >= DepthW) sum = sum - DepthW;
		return sum[AW-1:0];
	endfunction

	assign new_id    = next_id_q + 1'b1;
	assign k_m1      = k_q - 1'b1;
	assign wr_addr   = phys(head_q, k_q);
	assign rd_addr   = cmd.rd_head ? head_q : phys(head_q, k_m1);
	assign head_nxt  = phys(head_q, AW'(1));
	assign wr_data   = cmd.wr_new ? {amount_q, new_id} : rdata_q;
	assign rd_amount = rdata_q[MW-1:smpq_pkg::IdW];

	// Status to controller
	always_comb begin
		sts.is_pop     = action_q;
		sts.limit_hit  = admitted_q >= total_limit_q;
		sts.ins_ok     = (32'(count_q) < 32'(capacity_q)) && (32'(count_q) < QUEUE_DEPTH)
		                 && (amount_q < threshold_q);
		sts.not_empty  = count_q != '0;
		sts.k_one      = k_q == AW'(1);
		sts.rd_greater = rd_amount > amount_q;
		sts.out_free   = !out_valid_q || out_ready;
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_limit_q <= smpq_pkg::TotalLimitRst;
			capacity_q    <= smpq_pkg::CapacityRst;
			threshold_q   <= smpq_pkg::ThresholdRst;
		end else if (cfg_we) begin
			case (cfg_idx)
				smpq_pkg::CFG_TOTAL_LIMIT: total_limit_q <= cfg_wdata[smpq_pkg::LimitW-1:0];
				smpq_pkg::CFG_CAPACITY:    capacity_q    <= cfg_wdata[smpq_pkg::CapW-1:0];
				smpq_pkg::CFG_THRESHOLD:   threshold_q   <= cfg_wdata;
				default:                   threshold_q   <= threshold_q;
			endcase
		end
	end

	// Store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.wr_shift || cmd.wr_new) mem[wr_addr] <= wr_data;
		if (cmd.rd_en) rdata_q <= mem[rd_addr];
	end

	// Item capture and walk index
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			action_q <= in_action;
			amount_q <= in_amount;
		end
		if (cmd.k_load) k_q <= count_q[AW-1:0];
		else if (cmd.k_dec) k_q <= k_m1;
	end

	// Queue counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			count_q    <= '0;
			next_id_q  <= '0;
			admitted_q <= '0;
		end else if (cmd.ins_commit) begin
			count_q    <= count_q + 1'b1;
			next_id_q  <= new_id;
			admitted_q <= admitted_q + 1'b1;
		end else if (cmd.pop_commit) begin
			head_q  <= head_nxt;
			count_q <= count_q - 1'b1;
		end
	end

	// Result id
	always_ff @(posedge clk) begin
		case (cmd.res_sel)
			smpq_pkg::RES_ZERO: res_id_q <= '0;
			smpq_pkg::RES_NEW:  res_id_q <= new_id;
			smpq_pkg::RES_POP:  res_id_q <= rdata_q[smpq_pkg::IdW-1:0];
			default:            res_id_q <= res_id_q;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_id_q     <= res_id_q;
			out_amount_q <= amount_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_id     = out_id_q;
	assign out_amount = out_amount_q;

endmodule

>>> src/stable_min_priority_queue_core.sv
// Top level of the stable minimum priority queue.
//
// Input stream: s_tuser selects the operation (0 insert, 1 pop), s_tdata
// carries the signed amount. Every transfer in gives one transfer out on
// m_tdata: the entry id (0 when rejected or empty) and the amount echoed.
// Config writes go over cfg_valid/cfg_ready (always ready) with cfg_index
// 0 total limit, 1 capacity, 2 amount threshold; other indexes are ignored.
// The store is a circular buffer in one memory with one write and one
// registered read port. A rejected input goes from the decide state
// straight to the output register; a pop reads the head entry first. An
// insert walks from the tail, reading each entry and moving each larger
// entry up one slot, then writes the new entry into the slot left free,
// which is the head when all entries were larger (always on an empty queue).
// One item is worked on at a time; the next item is taken once the
// previous result sits in the output register, even if m_tready is low.
// A stalled receiver holds the result and, one item later, the core.
// Reset empties the queue, clears the id and admission counters, and
// returns the registers to their defaults; the store needs no clearing.
`timescale 1ns / 1ps

module stable_min_priority_queue_core #(
	parameter int QUEUE_DEPTH = smpq_pkg::QueueDepthDef
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] amount
	input  logic [0:0]  s_tuser,   // [0] action
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [15:0] entry_id, [47:16] amount_echo
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [smpq_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [31:0] cfg_data
);

	smpq_pkg::cmd_t    cmd;
	smpq_pkg::status_t sts;
	logic [smpq_pkg::IdW-1:0]            out_id;
	logic signed [smpq_pkg::AmountW-1:0] out_amount;

	assign cfg_ready = 1'b1;

	smpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	smpq_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_action  (s_tuser[0]),
		.in_amount  (s_tdata),
		.cfg_we     (cfg_valid),
		.cfg_idx    (cfg_index),
		.cfg_wdata  (cfg_data),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_id     (out_id),
		.out_amount (out_amount),
		.cmd        (cmd),
		.sts        (sts)
	);

	assign m_tdata = {out_amount, out_id};

endmodule

>>> bench/stable_min_priority_queue_core_tb.sv
// Self-checking testbench for the stable minimum priority queue core.
`timescale 1ns / 1ps

module stable_min_priority_queue_core_tb;

	localparam int Depth = smpq_pkg::QueueDepthDef;
	localparam int CycleLimit = 2_000_000;
	localparam int LongHold = 400;
	localparam int SettleCycles = 8;
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_POP = 1'b1;
	// index past the register list, must be ignored
	localparam logic [smpq_pkg::CfgIdxW-1:0] CfgUnusedIdx = 2'd3;

	typedef struct {
		logic               pop;
		logic signed [31:0] amount;
		int                 gap;
		bit                 drain_first;
	} op_item_t;

	typedef struct {
		logic [smpq_pkg::IdW-1:0] id;
		logic signed [31:0]       amount;
	} entry_t;

	typedef struct {
		logic [smpq_pkg::IdW-1:0] id;
		logic [31:0]              echo;
	} result_t;

	// DUT signals
	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [31:0]                  s_tdata = '0;    // [31:0] amount
	logic [0:0]                   s_tuser = '0;    // [0] action
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [47:0]                  m_tdata;         // [15:0] entry_id, [47:16] amount_echo
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [smpq_pkg::CfgIdxW-1:0] cfg_index = '0;
	logic [31:0]                  cfg_data = '0;

	// predictor state and register copies
	entry_t                              held_q[$];
	logic [smpq_pkg::IdW-1:0]            last_id = '0;
	logic [smpq_pkg::LimitW-1:0]         admitted = '0;
	logic [smpq_pkg::LimitW-1:0]         lim_reg = smpq_pkg::TotalLimitRst;
	logic [smpq_pkg::CapW-1:0]           cap_reg = smpq_pkg::CapacityRst;
	logic signed [smpq_pkg::AmountW-1:0] thr_reg = smpq_pkg::ThresholdRst;

	// bench bookkeeping
	op_item_t item_q[$];
	result_t  exp_q[$];
	int       pushed_cnt = 0;
	int       taken_cnt = 0;
	int       out_cnt = 0;
	int       err_cnt = 0;
	int       cycle_cnt = 0;
	bit       rx_fast = 1'b0;
	bit       hold_req = 1'b0;

	stable_min_priority_queue_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// Sorted insert or head pop; returns the id the block should report
	function automatic logic [smpq_pkg::IdW-1:0] queue_apply(logic pop,
			logic signed [31:0] amt);
		int cap_eff;
		int pos;
		entry_t ent;
		logic [smpq_pkg::IdW-1:0] id;
		id = '0;
		cap_eff = (int'(cap_reg) < Depth) ? int'(cap_reg) : Depth;
		if (admitted < lim_reg) begin
			if (pop == OP_INSERT) begin
				if (held_q.size() < cap_eff && amt < thr_reg) begin
					pos = 0;
					// equal amounts go behind those already held
					while (pos < held_q.size() && held_q[pos].amount <= amt)
						pos++;
					last_id = last_id + 1'b1;
					admitted = admitted + 1'b1;
					ent.id = last_id;
					ent.amount = amt;
					held_q.insert(pos, ent);
					id = last_id;
				end
			end else if (held_q.size() != 0) begin
				id = held_q[0].id;
				held_q.delete(0);
			end
		end
		return id;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
		err_cnt++;
	endtask

	// Random amount: ties near zero, values around the threshold, extremes, anything
	function automatic logic [31:0] pick_amount();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 32'($urandom_range(0, 16)) - 32'd8;
			4: return thr_reg + 32'($urandom_range(0, 2)) - 32'd1;
			5: begin
				case ($urandom_range(0, 3))
					0: return 32'h8000_0000;
					1: return 32'h7FFF_FFFF;
					2: return 32'h0000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			default: return $urandom();
		endcase
	endfunction

	task automatic push_op(logic pop, logic [31:0] amt, int gap, bit drain);
		op_item_t it;
		it.pop = pop;
		it.amount = amt;
		it.gap = gap;
		it.drain_first = drain;
		item_q.push_back(it);
		pushed_cnt++;
	endtask

	task automatic push_random(int n, int pop_pct, int drain_pct, bit all_fast);
		bit fast;
		logic pop;
		fast = all_fast;
		for (int i = 0; i < n; i++) begin
			// stretches of back-to-back items
			if (i % 16 == 0)
				fast = all_fast || ($urandom_range(0, 3) == 0);
			pop = ($urandom_range(0, 99) < pop_pct) ? OP_POP : OP_INSERT;
			push_op(pop, pick_amount(), fast ? 0 : $urandom_range(0, 19),
				$urandom_range(0, 99) < drain_pct);
		end
	endtask

	// Register write; the copy is updated at the transfer edge
	task automatic write_reg(logic [smpq_pkg::CfgIdxW-1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			smpq_pkg::CFG_TOTAL_LIMIT: lim_reg = val[smpq_pkg::LimitW-1:0];
			smpq_pkg::CFG_CAPACITY: cap_reg = val[smpq_pkg::CapW-1:0];
			smpq_pkg::CFG_THRESHOLD: thr_reg = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// All items taken and all results back, then let the core go quiet
	task automatic wait_idle();
		while (taken_cnt != pushed_cnt || exp_q.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// Input driver
	always @(negedge clk) begin : drv
		static op_item_t staged_item;
		static bit staged = 1'b0;
		static int gap_left = 0;
		static int offered_cnt = 0;
		if (arst_n) begin
			if (!s_tvalid || taken_cnt == offered_cnt) begin
				if (!staged && item_q.size() != 0) begin
					staged_item = item_q.pop_front();
					staged = 1'b1;
					gap_left = staged_item.gap;
				end
				if (staged && gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (staged && (!staged_item.drain_first || exp_q.size() == 0)) begin
					s_tvalid <= 1'b1;
					s_tdata <= staged_item.amount;
					s_tuser <= staged_item.pop;
					offered_cnt++;
					staged = 1'b0;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver ready: per-result stall, plus one long hold-off on request
	always @(negedge clk) begin : rx
		static int rx_seen = 0;
		static int rx_wait = 0;
		static int hold_left = 0;
		if (arst_n) begin
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = LongHold;
			end
			if (out_cnt != rx_seen) begin
				rx_seen = out_cnt;
				rx_wait = rx_fast ? 0 : $urandom_range(0, 19);
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Monitor: predict on input transfers, check output transfers
	always @(posedge clk) begin : mon
		result_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				taken_cnt++;
				want.id = queue_apply(s_tuser[0], s_tdata);
				want.echo = s_tdata;
				exp_q.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				out_cnt++;
				if (exp_q.size() == 0) begin
					report_mismatch("result with none pending", m_tdata[31:0], '0);
				end else begin
					want = exp_q.pop_front();
					if (m_tdata[15:0] !== want.id)
						report_mismatch("entry_id", 32'(m_tdata[15:0]), 32'(want.id));
					if (m_tdata[47:16] !== want.echo)
						report_mismatch("amount_echo", m_tdata[47:16], want.echo);
				end
			end
		end
	end

	// Timeout
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CycleLimit) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Stimulus
	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults: empty pop, extremes, threshold edge, tie ordering
		push_op(OP_POP, 32'h7FFF_FFFF, $urandom_range(0, 19), 1'b0);
		push_op(OP_INSERT, 32'h8000_0000, $urandom_range(0, 19), 1'b0);
		push_op(OP_INSERT, 32'd1999, $urandom_range(0, 19), 1'b0);
		push_op(OP_INSERT, 32'd2000, $urandom_range(0, 19), 1'b0);
		push_op(OP_INSERT, 32'h7FFF_FFFF, $urandom_range(0, 19), 1'b0);
		push_op(OP_INSERT, 32'd5, $urandom_range(0, 19), 1'b0);
		push_op(OP_INSERT, 32'd5, $urandom_range(0, 19), 1'b0);
		push_op(OP_INSERT, 32'h8000_0000, $urandom_range(0, 19), 1'b0);
		push_op(OP_POP, 32'h8000_0000, $urandom_range(0, 19), 1'b0);
		push_op(OP_POP, 32'hFFFF_FFFF, $urandom_range(0, 19), 1'b0);
		push_op(OP_POP, 32'h0000_0000, $urandom_range(0, 19), 1'b0);
		wait_idle();

		// small capacity, threshold at its top: full queue and threshold reject
		write_reg(smpq_pkg::CFG_CAPACITY, 32'd3);
		write_reg(smpq_pkg::CFG_THRESHOLD, 32'h7FFF_FFFF);
		push_op(OP_INSERT, 32'h7FFF_FFFE, $urandom_range(0, 19), 1'b0);
		push_op(OP_INSERT, 32'd1, $urandom_range(0, 19), 1'b0);
		push_op(OP_POP, 32'd0, $urandom_range(0, 19), 1'b0);
		push_op(OP_INSERT, 32'h7FFF_FFFF, $urandom_range(0, 19), 1'b0);
		wait_idle();

		// zero capacity and threshold at its bottom; unused index ignored
		write_reg(smpq_pkg::CFG_CAPACITY, 32'd0);
		write_reg(smpq_pkg::CFG_THRESHOLD, 32'h8000_0000);
		write_reg(CfgUnusedIdx, $urandom());
		push_op(OP_INSERT, 32'h8000_0000, $urandom_range(0, 19), 1'b0);
		push_op(OP_POP, 32'h1234_5678, $urandom_range(0, 19), 1'b0);
		wait_idle();

		// admission limit reached: inserts and pops both rejected
		write_reg(smpq_pkg::CFG_CAPACITY, 32'd127);
		write_reg(smpq_pkg::CFG_THRESHOLD, 32'd2000);
		write_reg(smpq_pkg::CFG_TOTAL_LIMIT, 32'(admitted + 1'b1));
		push_op(OP_INSERT, 32'd3, $urandom_range(0, 19), 1'b0);
		push_op(OP_INSERT, 32'd4, $urandom_range(0, 19), 1'b0);
		push_op(OP_POP, 32'd0, $urandom_range(0, 19), 1'b0);
		wait_idle();
		write_reg(smpq_pkg::CFG_TOTAL_LIMIT, 32'd0);
		push_op(OP_POP, 32'd0, $urandom_range(0, 19), 1'b0);
		wait_idle();
		write_reg(smpq_pkg::CFG_TOTAL_LIMIT, 32'hFFFF);

		// random mix at defaults, capacity above depth
		push_random(400, 40, 0, 1'b0);
		wait_idle();

		// fill to full depth, then drain, receiver never stalls
		write_reg(smpq_pkg::CFG_THRESHOLD, 32'h7FFF_FFFF);
		rx_fast = 1'b1;
		push_random(300, 20, 0, 1'b0);
		push_random(200, 70, 0, 1'b1);
		wait_idle();
		rx_fast = 1'b0;

		// long receiver hold-off while items keep coming
		write_reg(smpq_pkg::CFG_CAPACITY, 32'd64);
		hold_req = 1'b1;
		push_random(40, 50, 0, 1'b1);
		wait_idle();

		// small capacities, sender waits for all results now and then
		write_reg(smpq_pkg::CFG_CAPACITY, 32'($urandom_range(1, 10)));
		write_reg(smpq_pkg::CFG_THRESHOLD, 32'($urandom_range(0, 40)) - 32'd20);
		push_op(OP_INSERT, pick_amount(), 0, 1'b1);
		push_random(200, 45, 5, 1'b0);
		wait_idle();

		// assorted capacities and thresholds
		for (int p = 0; p < 5; p++) begin
			write_reg(smpq_pkg::CFG_CAPACITY, 32'($urandom_range(0, 127)));
			write_reg(smpq_pkg::CFG_THRESHOLD,
				(p == 0) ? $urandom() : 32'($urandom_range(0, 4000)) - 32'd1000);
			push_random(60, 40, 0, 1'b0);
			wait_idle();
		end

		// run into the admission limit, then lift it
		write_reg(smpq_pkg::CFG_CAPACITY, 32'd64);
		write_reg(smpq_pkg::CFG_TOTAL_LIMIT, 32'(admitted + 16'd20));
		push_random(100, 30, 0, 1'b0);
		wait_idle();
		write_reg(smpq_pkg::CFG_TOTAL_LIMIT, 32'hFFFF);
		write_reg(smpq_pkg::CFG_THRESHOLD, 32'd2000);
		push_random(40, 60, 0, 1'b0);
		wait_idle();

		repeat (20) @(posedge clk);
		if (err_cnt == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

>>> sim.f
src/smpq_pkg.sv
src/smpq_ctrl.sv
src/smpq_datapath.sv
src/stable_min_priority_queue_core.sv
bench/stable_min_priority_queue_core_tb.sv
